/* rtl/sobs_pkg.sv */
`default_nettype none

package sobs_pkg;

	// default sizes of the stack set
	localparam int MAX_STACKS_DEF = 16;
	localparam int MAX_DEPTH_DEF  = 16;

	// request and result field widths
	localparam int OPCODE_W = 2;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 2;
	localparam int CAP_W    = 5;

	// stream data widths, fields packed from bit 0 and padded to bytes
	localparam int IN_BITS     = OPCODE_W + VALUE_W + POS_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = VALUE_W + STATUS_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_POP_AT = 2'd2
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_DROP  = 2'd2
	} status_t;

endpackage

`default_nettype wire

/* rtl/sobs_plate_mem.sv */
`default_nettype none

module sobs_plate_mem #(
	parameter int DEPTH  = sobs_pkg::MAX_STACKS_DEF * sobs_pkg::MAX_DEPTH_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [ADDR_W-1:0]            waddr,
	input  wire logic [sobs_pkg::VALUE_W-1:0] wdata,
	input  wire logic                         re,
	input  wire logic [ADDR_W-1:0]            raddr,
	output logic      [sobs_pkg::VALUE_W-1:0] rdata
);

	logic [sobs_pkg::VALUE_W-1:0] mem [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/set_of_bounded_stacks_core.sv */
// flow: a taken request passes through the execute and emit states; its result is
//   registered into the output in the emit state, after the registered plate memory read
// one request at a time: no new request is taken until the result of the last one is
//   loaded into the output; a stalled output holds the next result in place
// reset: arst_n clears fill counts, live stack count and control, restores the
//   identity slot order and capacity 16; plate memory contents are left as they are
`default_nettype none

module set_of_bounded_stacks_core #(
	parameter int MAX_STACKS = sobs_pkg::MAX_STACKS_DEF,
	parameter int MAX_DEPTH  = sobs_pkg::MAX_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// capacity register
	input  wire logic                              cfg_we,
	input  wire logic [sobs_pkg::CAP_W-1:0]        cfg_wdata,
	// request: opcode, push_value, stack_position (from bit 0 up)
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [sobs_pkg::IN_TDATA_W-1:0]   s_tdata,
	// result: popped_value, status (from bit 0 up)
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [sobs_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	localparam int SLOT_W = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
	localparam int CNT_W  = $clog2(MAX_STACKS + 1);
	localparam int FILL_W = $clog2(MAX_DEPTH + 1);
	localparam int MEM_D  = MAX_STACKS * MAX_DEPTH;
	localparam int ADDR_W = (MEM_D > 1) ? $clog2(MEM_D) : 1;
	localparam int CMP_W  = (CNT_W > sobs_pkg::POS_W) ? CNT_W : sobs_pkg::POS_W;
	localparam int CAPX_W = (FILL_W > sobs_pkg::CAP_W) ? FILL_W : sobs_pkg::CAP_W;
	localparam int VW     = sobs_pkg::VALUE_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_EMIT
	} state_t;

	state_t state_q;

	// request registers
	logic [sobs_pkg::OPCODE_W-1:0] op_q;
	logic [VW-1:0]                 val_q;
	logic [sobs_pkg::POS_W-1:0]    pos_q;

	// stack bookkeeping
	logic [SLOT_W-1:0]          order_q [MAX_STACKS];
	logic [FILL_W-1:0]          fill_q  [MAX_STACKS];
	logic [CNT_W-1:0]           siu_q;
	logic [sobs_pkg::CAP_W-1:0] cap_q;

	// pending result
	logic                             res_pop_q;
	sobs_pkg::status_t                res_status_q;
	logic [sobs_pkg::OUT_TDATA_W-1:0] m_tdata_q;
	logic                             m_tvalid_q;

	// memory port
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [VW-1:0]     mem_rdata;

	// execute stage decode
	logic [CAPX_W-1:0]  cap_x;
	logic [FILL_W-1:0]  eff_cap;
	logic [CNT_W-1:0]   last_pos;
	logic [CMP_W-1:0]   tpos_x;
	logic [SLOT_W-1:0]  t_slot;
	logic [FILL_W-1:0]  t_fill;
	logic [FILL_W-1:0]  t_fill_dec;
	logic [SLOT_W-1:0]  n_slot;
	logic               is_push;
	logic               is_pop;
	logic               pop_hit;
	logic               push_fits;
	logic               push_open;
	logic [SLOT_W-1:0]  order_shift [MAX_STACKS];

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// capacity saturated to the stack depth
	assign cap_x   = CAPX_W'(cap_q);
	assign eff_cap = (cap_x > CAPX_W'(MAX_DEPTH)) ? FILL_W'(MAX_DEPTH) : FILL_W'(cap_x);

	// target stack lookup
	always_comb begin
		is_push = 1'b0;
		is_pop  = 1'b0;
		last_pos = siu_q - CNT_W'(1);
		tpos_x   = CMP_W'(last_pos);
		unique case (op_q)
			sobs_pkg::OP_PUSH: begin
				is_push = 1'b1;
			end
			sobs_pkg::OP_POP: begin
				is_pop = 1'b1;
			end
			sobs_pkg::OP_POP_AT: begin
				is_pop = 1'b1;
				tpos_x = CMP_W'(pos_q);
			end
			default: begin
				is_pop = 1'b0;
			end
		endcase
		t_slot     = order_q[tpos_x[SLOT_W-1:0]];
		t_fill     = fill_q[t_slot];
		t_fill_dec = t_fill - FILL_W'(1);
		n_slot     = order_q[siu_q[SLOT_W-1:0]];
		pop_hit    = is_pop && (tpos_x < CMP_W'(siu_q)) && (t_fill != '0);
		push_fits  = is_push && (eff_cap != '0) && (siu_q != '0) && (t_fill < eff_cap);
		push_open  = is_push && (eff_cap != '0) && !push_fits
		             && (int'(siu_q) < MAX_STACKS);
	end

	// order table with the emptied stack moved to the end of the live range
	always_comb begin
		for (int i = 0; i < MAX_STACKS - 1; i++) begin
			if ((i >= int'(tpos_x)) && (i + 1 < int'(siu_q))) begin
				order_shift[i] = order_q[i + 1];
			end else if (i == int'(siu_q) - 1) begin
				order_shift[i] = t_slot;
			end else begin
				order_shift[i] = order_q[i];
			end
		end
		if (MAX_STACKS - 1 == int'(siu_q) - 1) begin
			order_shift[MAX_STACKS-1] = t_slot;
		end else begin
			order_shift[MAX_STACKS-1] = order_q[MAX_STACKS-1];
		end
	end

	// plate memory access
	always_comb begin
		mem_we    = (state_q == S_EXEC) && (push_fits || push_open);
		mem_waddr = push_fits
		            ? ADDR_W'(t_slot) * ADDR_W'(MAX_DEPTH) + ADDR_W'(t_fill)
		            : ADDR_W'(n_slot) * ADDR_W'(MAX_DEPTH);
		mem_re    = (state_q == S_EXEC) && pop_hit;
		mem_raddr = ADDR_W'(t_slot) * ADDR_W'(MAX_DEPTH) + ADDR_W'(t_fill_dec);
	end

	sobs_plate_mem #(
		.DEPTH  (MEM_D),
		.ADDR_W (ADDR_W)
	) u_plate_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (val_q),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= sobs_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= s_tdata[sobs_pkg::OPCODE_W-1:0];
			val_q <= s_tdata[sobs_pkg::OPCODE_W +: VW];
			pos_q <= s_tdata[sobs_pkg::OPCODE_W + VW +: sobs_pkg::POS_W];
		end
	end

	// sequencer, bookkeeping and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			siu_q        <= '0;
			res_pop_q    <= 1'b0;
			res_status_q <= sobs_pkg::ST_OK;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			for (int i = 0; i < MAX_STACKS; i++) begin
				order_q[i] <= SLOT_W'(i);
				fill_q[i]  <= '0;
			end
		end else begin
			// drain outside the emit state, which reloads the output itself
			if (m_tvalid_q && m_tready && (state_q != S_EMIT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q   <= S_EMIT;
					res_pop_q <= pop_hit;
					if (pop_hit) begin
						res_status_q   <= sobs_pkg::ST_OK;
						fill_q[t_slot] <= t_fill_dec;
						if (t_fill_dec == '0) begin
							order_q <= order_shift;
							siu_q   <= siu_q - CNT_W'(1);
						end
					end else if (push_fits) begin
						res_status_q   <= sobs_pkg::ST_OK;
						fill_q[t_slot] <= t_fill + FILL_W'(1);
					end else if (push_open) begin
						res_status_q   <= sobs_pkg::ST_OK;
						fill_q[n_slot] <= FILL_W'(1);
						siu_q          <= siu_q + CNT_W'(1);
					end else if (is_push) begin
						res_status_q <= sobs_pkg::ST_DROP;
					end else begin
						res_status_q <= sobs_pkg::ST_EMPTY;
					end
				end
				S_EMIT: begin
					// load the output when it is free or being drained
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= sobs_pkg::OUT_TDATA_W'({res_status_q,
						              (res_pop_q ? mem_rdata : VW'(0))});
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/sobs_checker.sv */
`default_nettype none

module sobs_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [sobs_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int VW = sobs_pkg::VALUE_W;

	logic [sobs_pkg::STATUS_W-1:0] status;
	assign status = m_tdata[VW +: sobs_pkg::STATUS_W];

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// status is one of the three defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (status == sobs_pkg::ST_OK) || (status == sobs_pkg::ST_EMPTY)
		             || (status == sobs_pkg::ST_DROP))
		else $error("undefined status code");

	// failures carry a zero value
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status != sobs_pkg::ST_OK) |-> m_tdata[VW-1:0] == '0)
		else $error("failed request carries a value");

	// one request in flight: the block is busy right after taking one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in flight");

	// a result appears only after a request was taken
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a request");

endmodule

bind set_of_bounded_stacks_core sobs_checker u_sobs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/sobs_result_checker.sv */
`timescale 1ns / 1ps

module sobs_result_checker
	import sobs_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CAP_W-1:0]        cfg_wdata,
	input  wire logic                    s_tvalid,
	input  wire logic                    s_tready,
	input  wire logic [IN_TDATA_W-1:0]   s_tdata,
	input  wire logic                    m_tvalid,
	input  wire logic                    m_tready,
	input  wire logic [OUT_TDATA_W-1:0]  m_tdata,
	output int                           errors,
	output int                           results,
	output int                           ok_count,
	output int                           empty_count,
	output int                           drop_count
);

	localparam int MAX_STACKS = MAX_STACKS_DEF;
	localparam int MAX_DEPTH  = MAX_DEPTH_DEF;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		status_t            status;
	} outcome_t;

	// shadow of the stack set
	logic [VALUE_W-1:0] plates [MAX_STACKS][MAX_DEPTH];
	int                 fill [MAX_STACKS];
	int                 order [MAX_STACKS];
	int                 live;
	int                 capacity;
	outcome_t           expected_results [$];

	initial begin
		for (int i = 0; i < MAX_STACKS; i++) begin
			fill[i]  = 0;
			order[i] = i;
		end
		live        = 0;
		capacity    = CAP_RESET;
		errors      = 0;
		results     = 0;
		ok_count    = 0;
		empty_count = 0;
		drop_count  = 0;
	end

	// remove the top of the stack at a logical position, closing the gap if it empties
	function automatic outcome_t take_top(input int pos);
		outcome_t o;
		int       slot;
		int       f;
		int       i;
		o.value  = '0;
		o.status = ST_EMPTY;
		if (pos >= live)
			return o;
		slot = order[pos];
		f    = fill[slot];
		if (f == 0)
			return o;
		f          = f - 1;
		o.value    = plates[slot][f];
		o.status   = ST_OK;
		fill[slot] = f;
		if (f == 0) begin
			for (i = pos; i + 1 < live; i++)
				order[i] = order[i + 1];
			order[live - 1] = slot;
			live = live - 1;
		end
		return o;
	endfunction

	// push onto the last stack, open a new one if it is full or absent, else drop
	function automatic status_t push_plate(input logic [VALUE_W-1:0] v);
		int limit;
		int slot;
		limit = (capacity > MAX_DEPTH) ? MAX_DEPTH : capacity;
		if (limit == 0)
			return ST_DROP;
		if (live != 0) begin
			slot = order[live - 1];
			if (fill[slot] < limit) begin
				plates[slot][fill[slot]] = v;
				fill[slot] = fill[slot] + 1;
				return ST_OK;
			end
		end
		if (live >= MAX_STACKS)
			return ST_DROP;
		slot = order[live];
		plates[slot][0] = v;
		fill[slot] = 1;
		live = live + 1;
		return ST_OK;
	endfunction

	function automatic outcome_t predict_request(input logic [OPCODE_W-1:0] op,
			input logic [VALUE_W-1:0] v, input logic [POS_W-1:0] pos);
		outcome_t o;
		o.value  = '0;
		o.status = ST_EMPTY;
		case (op)
			OP_PUSH: begin
				o.status = push_plate(v);
			end
			OP_POP: begin
				if (live != 0)
					o = take_top(live - 1);
			end
			OP_POP_AT: begin
				o = take_top(int'(pos));
			end
			default: begin
				o.status = ST_EMPTY;
			end
		endcase
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
			input logic [VALUE_W-1:0] want);
		$display("mismatch at result %0d: %s got %0h expected %0h", results, what, got,
			want);
		errors++;
	endtask

	// compare results, then predict newly taken requests
	always @(posedge clk) begin : watch
		outcome_t            want;
		outcome_t            predicted;
		logic [VALUE_W-1:0]  got_value;
		logic [STATUS_W-1:0] got_status;
		if (arst_n) begin
			if (cfg_we)
				capacity = int'(cfg_wdata);
			if (m_tvalid && m_tready) begin
				got_value  = m_tdata[VALUE_W-1:0];
				got_status = m_tdata[VALUE_W +: STATUS_W];
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request waiting, value", got_value, '0);
				end else begin
					want = expected_results.pop_front();
					if (got_value != want.value)
						report_mismatch("popped_value", got_value, want.value);
					if (got_status != want.status)
						report_mismatch("status", VALUE_W'(got_status), VALUE_W'(want.status));
					case (want.status)
						ST_OK:    ok_count++;
						ST_EMPTY: empty_count++;
						default:  drop_count++;
					endcase
				end
				results++;
			end
			if (s_tvalid && s_tready) begin
				predicted = predict_request(s_tdata[OPCODE_W-1:0],
					s_tdata[OPCODE_W +: VALUE_W], s_tdata[OPCODE_W + VALUE_W +: POS_W]);
				expected_results.insert(expected_results.size(), predicted);
			end
		end
	end

endmodule

/* tb/set_of_bounded_stacks_core_tb.sv */
`timescale 1ns / 1ps

module set_of_bounded_stacks_core_tb;
	import sobs_pkg::*;

	// opcode with no operation behind it
	localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;
	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASE_ITEMS   = 82;
	localparam int CALM_PHASE    = 3;
	localparam int PHASES        = 10;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CAP_W-1:0]       cfg_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // opcode, push_value, stack_position
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // popped_value, status

	int mismatches;
	int results;
	int ok_count;
	int empty_count;
	int drop_count;
	int sent;
	int settings;
	int quiet;
	bit calm;

	set_of_bounded_stacks_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	sobs_result_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.errors      (mismatches),
		.results     (results),
		.ok_count    (ok_count),
		.empty_count (empty_count),
		.drop_count  (drop_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side backpressure
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 21);
	end

	// watchdog on cycles with no traffic at all
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet = 0;
		else
			quiet = quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("no traffic for %0d cycles", QUIET_LIMIT);
			$display("set_of_bounded_stacks_core_tb failed");
			$finish;
		end
	end

	task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] v,
			input logic [POS_W-1:0] pos);
		while (!calm && $urandom_range(0, 99) < 21) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, pos, v, op};
		do begin
			@(posedge clk);
		end while (!s_tready);
		sent++;
	endtask

	// capacity changes only once every result is back
	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		s_tvalid <= 1'b0;
		while (results < sent)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	function automatic logic [VALUE_W-1:0] random_value();
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0:       return '0;
				1:       return '1;
				2:       return 32'h8000_0000;
				default: return 32'h7fff_ffff;
			endcase
		end
		return $urandom();
	endfunction

	initial begin : stimulus
		int                  caps [PHASES];
		int                  push_pct;
		int                  pick;
		logic [OPCODE_W-1:0] op;
		logic [POS_W-1:0]    pos;
		caps = '{31, 2, 1, 16, 0, 5, 1, 3, 8, 16};
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		sent      = 0;
		settings  = 0;
		quiet     = 0;
		calm      = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pops, unused opcode, extreme values, out of range position
		send_request(OP_POP, '0, '0);
		send_request(OP_POP_AT, '0, '0);
		send_request(OP_NONE, '1, '1);
		send_request(OP_PUSH, 32'h7fff_ffff, '0);
		send_request(OP_PUSH, 32'h8000_0000, '1);
		send_request(OP_POP_AT, '0, 4'd15);
		send_request(OP_POP_AT, '0, 4'd0);
		send_request(OP_POP, '0, '0);

		// zero capacity drops the push
		set_capacity(5'd0);
		send_request(OP_PUSH, 32'h1234_5678, '0);

		// one value per stack: fill every slot, then one more is dropped
		set_capacity(5'd1);
		send_request(OP_PUSH, '0, '0);
		send_request(OP_PUSH, '1, '0);
		for (int i = 2; i <= MAX_STACKS_DEF; i++)
			send_request(OP_PUSH, $urandom(), '0);

		// random phases over a spread of capacities, one phase without idling
		for (int p = 0; p < PHASES; p++) begin
			set_capacity(CAP_W'(caps[p]));
			calm = (p == CALM_PHASE);
			push_pct = 50;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 16 == 0)
					push_pct = $urandom_range(25, 85);
				pick = $urandom_range(0, 99);
				if (pick < push_pct)
					op = OP_PUSH;
				else if ($urandom_range(0, 19) == 0)
					op = OP_NONE;
				else if ($urandom_range(0, 1) == 0)
					op = OP_POP;
				else
					op = OP_POP_AT;
				if ($urandom_range(0, 4) < 2)
					pos = POS_W'($urandom_range(0, 2));
				else
					pos = POS_W'($urandom_range(0, 15));
				send_request(op, random_value(), pos);
			end
		end
		calm = 1'b0;

		// drain and let any stray result show up
		s_tvalid <= 1'b0;
		while (results < sent)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d requests over %0d capacity settings", sent, settings);
		$display("results: %0d ok, %0d nothing to pop, %0d dropped pushes",
			ok_count, empty_count, drop_count);
		if (mismatches == 0) begin
			$display("set_of_bounded_stacks_core_tb passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("set_of_bounded_stacks_core_tb failed");
		end
		$finish;
	end

endmodule
